// ----- rtl/erd_pkg.sv -----
// shared types, widths and helpers for the eye ray direction block
// no dependencies
package erd_pkg;

  localparam int unsigned CrdW       = 16;
  localparam int unsigned CoefW      = 32;
  localparam int unsigned PW         = 18;
  localparam int unsigned ProdW      = 50;
  localparam int unsigned VW         = 52;
  localparam int unsigned MagW       = 51;
  localparam int unsigned BitLenW    = 6;
  localparam int unsigned NormW      = 31;
  localparam int unsigned SqW        = 62;
  localparam int unsigned SumW       = 64;
  localparam int unsigned LenW       = 32;
  localparam int unsigned DirW       = 16;
  localparam int unsigned QW         = 15;
  localparam int unsigned FracShift  = 14;
  localparam int unsigned RemW       = 47;
  localparam int unsigned IsqrtSteps = 32;
  localparam int unsigned Col3Shift  = 15;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam logic signed [PW-1:0] HalfOffset = PW'(32768);

  typedef enum logic [CfgIdxW-1:0] {
    RegRow0Cols01 = 3'd0,
    RegRow1Cols01 = 3'd1,
    RegRow2Cols01 = 3'd2,
    RegRow3Cols01 = 3'd3,
    RegRows01Col3 = 3'd4,
    RegRows23Col3 = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CrdW-1:0] screen_x;
    logic [CrdW-1:0] screen_y;
  } req_t;

  typedef struct packed {
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
    logic signed [DirW-1:0] dir_z;
    logic                   degenerate;
  } rsp_t;

  typedef struct packed {
    logic signed [CoefW-1:0] m00;
    logic signed [CoefW-1:0] m01;
    logic signed [CoefW-1:0] m03;
    logic signed [CoefW-1:0] m10;
    logic signed [CoefW-1:0] m11;
    logic signed [CoefW-1:0] m13;
    logic signed [CoefW-1:0] m20;
    logic signed [CoefW-1:0] m21;
    logic signed [CoefW-1:0] m23;
    logic signed [CoefW-1:0] m30;
    logic signed [CoefW-1:0] m31;
    logic signed [CoefW-1:0] m33;
  } mat_t;

  typedef struct packed {
    logic signed [VW-1:0] v0;
    logic signed [VW-1:0] v1;
    logic signed [VW-1:0] v2;
    logic signed [VW-1:0] w;
  } clip_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             degen;
    logic [NormW-1:0] a0;
    logic [NormW-1:0] a1;
    logic [NormW-1:0] a2;
    logic [SumW-1:0]  s;
  } norm_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             degen;
    logic [NormW-1:0] a0;
    logic [NormW-1:0] a1;
    logic [NormW-1:0] a2;
    logic [SumW-1:0]  rem;
    logic [SumW-1:0]  res;
  } sq_t;

  function automatic logic signed [ProdW-1:0] smul(logic signed [CoefW-1:0] a,
                                                  logic signed [PW-1:0] b);
    logic signed [ProdW-1:0] ae;
    logic signed [ProdW-1:0] be;
    ae = ProdW'(a);
    be = ProdW'(b);
    return ae * be;
  endfunction

endpackage

// ----- rtl/eye_ray_direction_top.sv -----
// eye ray direction top level: matrix registers and the four pipeline sections
// depends on erd_pkg, erd_transform, erd_normalize, erd_isqrt, erd_divide
//
// Turns a normalized screen point into a unit view ray direction through the
// configured inverse view-projection matrix. One request is taken every cycle
// while the output is not stalled; each request comes out in order after 3
// matrix, 6 normalize, 32 square root and 17 divide and output stages.
// The whole pipeline holds while a result waits at the output, so in_ready_o
// follows out_ready_i whenever the output register is full. Write the matrix
// registers only while no request is in flight.
module eye_ray_direction_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [erd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [erd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  erd_pkg::req_t                  in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output erd_pkg::rsp_t                  out_rsp_o
);
  import erd_pkg::*;

  logic [CfgDataW-1:0] r0_q, r1_q, r2_q, r3_q, r4_q, r5_q;
  mat_t mat;
  logic en;
  logic t_vld, n_vld, s_vld;
  clip_t clip;
  norm_t norm;
  sq_t sq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q <= 64'h0000_0000_0001_0000;
      r1_q <= 64'h0001_0000_0000_0000;
      r2_q <= '0;
      r3_q <= '0;
      r4_q <= '0;
      r5_q <= 64'h0001_0000_0000_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRow0Cols01: r0_q <= cfg_data_i;
        RegRow1Cols01: r1_q <= cfg_data_i;
        RegRow2Cols01: r2_q <= cfg_data_i;
        RegRow3Cols01: r3_q <= cfg_data_i;
        RegRows01Col3: r4_q <= cfg_data_i;
        RegRows23Col3: r5_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mat.m00 = signed'(r0_q[31:0]);
    mat.m01 = signed'(r0_q[63:32]);
    mat.m10 = signed'(r1_q[31:0]);
    mat.m11 = signed'(r1_q[63:32]);
    mat.m20 = signed'(r2_q[31:0]);
    mat.m21 = signed'(r2_q[63:32]);
    mat.m30 = signed'(r3_q[31:0]);
    mat.m31 = signed'(r3_q[63:32]);
    mat.m03 = signed'(r4_q[31:0]);
    mat.m13 = signed'(r4_q[63:32]);
    mat.m23 = signed'(r5_q[31:0]);
    mat.m33 = signed'(r5_q[63:32]);
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  erd_transform u_transform (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .req_i(in_req_i), .mat_i(mat),
    .vld_o(t_vld), .clip_o(clip)
  );

  erd_normalize u_normalize (
    .clk_i, .rst_ni, .en_i(en), .vld_i(t_vld), .clip_i(clip),
    .vld_o(n_vld), .norm_o(norm)
  );

  erd_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .vld_i(n_vld), .norm_i(norm),
    .vld_o(s_vld), .sq_o(sq)
  );

  erd_divide u_divide (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_vld), .sq_i(sq),
    .vld_o(out_valid_o), .rsp_o(out_rsp_o)
  );
endmodule

// ----- rtl/erd_transform.sv -----
// clip point build and matrix product, three stages
// depends on erd_pkg
module erd_transform (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  erd_pkg::req_t req_i,
  input  erd_pkg::mat_t mat_i,
  output logic          vld_o,
  output erd_pkg::clip_t clip_o
);
  import erd_pkg::*;

  logic vld1_q, vld2_q, vld3_q;
  logic signed [PW-1:0] px_q, py_q, px_d, py_d;
  logic signed [ProdW-1:0] p00_q, p01_q, p10_q, p11_q, p20_q, p21_q, p30_q, p31_q;
  logic signed [VW-1:0] c0_q, c1_q, c2_q, c3_q;
  clip_t clip_q, clip_d;

  assign px_d = signed'({1'b0, req_i.screen_x, 1'b0}) - HalfOffset;
  assign py_d = signed'({1'b0, req_i.screen_y, 1'b0}) - HalfOffset;

  always_comb begin
    clip_d.v0 = VW'(p00_q) + VW'(p01_q) + c0_q;
    clip_d.v1 = VW'(p10_q) + VW'(p11_q) + c1_q;
    clip_d.v2 = VW'(p20_q) + VW'(p21_q) + c2_q;
    clip_d.w  = VW'(p30_q) + VW'(p31_q) + c3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= px_d;
      py_q   <= py_d;
      p00_q  <= smul(mat_i.m00, px_q);
      p01_q  <= smul(mat_i.m01, py_q);
      p10_q  <= smul(mat_i.m10, px_q);
      p11_q  <= smul(mat_i.m11, py_q);
      p20_q  <= smul(mat_i.m20, px_q);
      p21_q  <= smul(mat_i.m21, py_q);
      p30_q  <= smul(mat_i.m30, px_q);
      p31_q  <= smul(mat_i.m31, py_q);
      c0_q   <= VW'(mat_i.m03) <<< Col3Shift;
      c1_q   <= VW'(mat_i.m13) <<< Col3Shift;
      c2_q   <= VW'(mat_i.m23) <<< Col3Shift;
      c3_q   <= VW'(mat_i.m33) <<< Col3Shift;
      clip_q <= clip_d;
    end
  end

  assign vld_o  = vld3_q;
  assign clip_o = clip_q;
endmodule

// ----- rtl/erd_normalize.sv -----
// magnitudes, common normalizing shift and sum of squares, six stages
// depends on erd_pkg
module erd_normalize (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  erd_pkg::clip_t clip_i,
  output logic           vld_o,
  output erd_pkg::norm_t norm_o
);
  import erd_pkg::*;

  logic [5:0] vld_q;
  logic [2:0] neg_q [6];
  logic       degen_q [6];
  logic [MagW-1:0] m0_q, m1_q, m2_q, m0b_q, m1b_q, m2b_q, m0c_q, m1c_q, m2c_q;
  logic [MagW-1:0] max_q, max_d;
  logic [BitLenW-1:0] blen_q, blen_d;
  logic [NormW-1:0] a0_q, a1_q, a2_q, a0b_q, a1b_q, a2b_q, a0c_q, a1c_q, a2c_q;
  logic [SqW-1:0] sq0_q, sq1_q, sq2_q;
  logic [SumW-1:0] s_q;
  logic [MagW-1:0] m0_d, m1_d, m2_d;
  logic [2:0] neg_d;
  logic degen_d;

  function automatic logic [MagW-1:0] mag(logic signed [VW-1:0] v);
    logic signed [VW-1:0] n;
    n = v[VW-1] ? -v : v;
    return n[MagW-1:0];
  endfunction

  function automatic logic [NormW-1:0] shift_norm(logic [MagW-1:0] m,
                                                  logic [BitLenW-1:0] b);
    logic [MagW-1:0] t;
    if (b > BitLenW'(NormW)) begin
      t = m >> (b - BitLenW'(NormW));
    end else begin
      t = m << (BitLenW'(NormW) - b);
    end
    return t[NormW-1:0];
  endfunction

  always_comb begin
    m0_d    = mag(clip_i.v0);
    m1_d    = mag(clip_i.v1);
    m2_d    = mag(clip_i.v2);
    neg_d   = {clip_i.v2[VW-1] ^ clip_i.w[VW-1], clip_i.v1[VW-1] ^ clip_i.w[VW-1],
               clip_i.v0[VW-1] ^ clip_i.w[VW-1]};
    degen_d = (clip_i.w == '0) ||
              (clip_i.v0 == '0 && clip_i.v1 == '0 && clip_i.v2 == '0);
  end

  always_comb begin
    max_d = m0_q;
    if (m1_q > max_d) begin
      max_d = m1_q;
    end
    if (m2_q > max_d) begin
      max_d = m2_q;
    end
  end

  always_comb begin
    blen_d = '0;
    for (int i = 0; i < MagW; i++) begin
      if (max_q[i]) begin
        blen_d = BitLenW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]   <= neg_d;
      degen_q[0] <= degen_d;
      for (int i = 1; i < 6; i++) begin
        neg_q[i]   <= neg_q[i-1];
        degen_q[i] <= degen_q[i-1];
      end
      m0_q  <= m0_d;
      m1_q  <= m1_d;
      m2_q  <= m2_d;
      max_q <= max_d;
      m0b_q <= m0_q;
      m1b_q <= m1_q;
      m2b_q <= m2_q;
      blen_q <= blen_d;
      m0c_q <= m0b_q;
      m1c_q <= m1b_q;
      m2c_q <= m2b_q;
      a0_q  <= shift_norm(m0c_q, blen_q);
      a1_q  <= shift_norm(m1c_q, blen_q);
      a2_q  <= shift_norm(m2c_q, blen_q);
      sq0_q <= SqW'(a0_q) * SqW'(a0_q);
      sq1_q <= SqW'(a1_q) * SqW'(a1_q);
      sq2_q <= SqW'(a2_q) * SqW'(a2_q);
      a0b_q <= a0_q;
      a1b_q <= a1_q;
      a2b_q <= a2_q;
      s_q   <= SumW'(sq0_q) + SumW'(sq1_q) + SumW'(sq2_q);
      a0c_q <= a0b_q;
      a1c_q <= a1b_q;
      a2c_q <= a2b_q;
    end
  end

  assign vld_o        = vld_q[5];
  assign norm_o.neg   = neg_q[5];
  assign norm_o.degen = degen_q[5];
  assign norm_o.a0    = a0c_q;
  assign norm_o.a1    = a1c_q;
  assign norm_o.a2    = a2c_q;
  assign norm_o.s     = s_q;
endmodule

// ----- rtl/erd_isqrt.sv -----
// integer square root, one result bit per stage
// depends on erd_pkg
module erd_isqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  erd_pkg::norm_t norm_i,
  output logic           vld_o,
  output erd_pkg::sq_t   sq_o
);
  import erd_pkg::*;

  logic [IsqrtSteps-1:0] vld_q;
  sq_t st_q [IsqrtSteps];
  sq_t init;

  always_comb begin
    init.neg   = norm_i.neg;
    init.degen = norm_i.degen;
    init.a0    = norm_i.a0;
    init.a1    = norm_i.a1;
    init.a2    = norm_i.a2;
    init.rem   = norm_i.s;
    init.res   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[IsqrtSteps-2:0], vld_i};
    end
  end

  for (genvar g = 0; g < IsqrtSteps; g++) begin : g_step
    localparam logic [SumW-1:0] StepBit = SumW'(1) << (SumW - 2 - 2 * g);
    sq_t prev, nxt;
    logic [SumW-1:0] trial;

    if (g == 0) begin : g_first
      assign prev = init;
    end else begin : g_rest
      assign prev = st_q[g-1];
    end

    always_comb begin
      nxt   = prev;
      trial = prev.res + StepBit;
      if (prev.rem >= trial) begin
        nxt.rem = prev.rem - trial;
        nxt.res = (prev.res >> 1) + StepBit;
      end else begin
        nxt.res = prev.res >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= nxt;
      end
    end
  end

  assign vld_o = vld_q[IsqrtSteps-1];
  assign sq_o  = st_q[IsqrtSteps-1];
endmodule

// ----- rtl/erd_divide.sv -----
// rounded component divide by length, one quotient bit per stage, sign and output register
// depends on erd_pkg
module erd_divide (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  erd_pkg::sq_t sq_i,
  output logic         vld_o,
  output erd_pkg::rsp_t rsp_o
);
  import erd_pkg::*;

  typedef struct packed {
    logic [2:0]      neg;
    logic            degen;
    logic [LenW-1:0] len;
    logic [RemW-1:0] r0;
    logic [RemW-1:0] r1;
    logic [RemW-1:0] r2;
    logic [QW-1:0]   q0;
    logic [QW-1:0]   q1;
    logic [QW-1:0]   q2;
  } div_t;

  localparam int unsigned Stages = QW + 2;

  logic [Stages-1:0] vld_q;
  div_t prep_q, prep_d;
  div_t st_q [QW];
  rsp_t rsp_q, rsp_d;
  logic [LenW-1:0] len;

  assign len = sq_i.res[LenW-1:0];

  always_comb begin
    prep_d.neg   = sq_i.neg;
    prep_d.degen = sq_i.degen;
    prep_d.len   = len;
    prep_d.r0    = {sq_i.a0, FracShift'(0)} + RemW'(len >> 1);
    prep_d.r1    = {sq_i.a1, FracShift'(0)} + RemW'(len >> 1);
    prep_d.r2    = {sq_i.a2, FracShift'(0)} + RemW'(len >> 1);
    prep_d.q0    = '0;
    prep_d.q1    = '0;
    prep_d.q2    = '0;
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    localparam int unsigned Sh = QW - 1 - g;
    div_t prev, nxt;
    logic [RemW-1:0] dv;

    if (g == 0) begin : g_first
      assign prev = prep_q;
    end else begin : g_rest
      assign prev = st_q[g-1];
    end

    always_comb begin
      nxt = prev;
      dv  = RemW'(prev.len) << Sh;
      if (prev.r0 >= dv) begin
        nxt.r0     = prev.r0 - dv;
        nxt.q0[Sh] = 1'b1;
      end
      if (prev.r1 >= dv) begin
        nxt.r1     = prev.r1 - dv;
        nxt.q1[Sh] = 1'b1;
      end
      if (prev.r2 >= dv) begin
        nxt.r2     = prev.r2 - dv;
        nxt.q2[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= nxt;
      end
    end
  end

  function automatic logic signed [DirW-1:0] apply_sign(logic [QW-1:0] q, logic n,
                                                       logic z);
    logic signed [DirW-1:0] m;
    m = signed'(DirW'(q));
    if (z) begin
      return '0;
    end
    return n ? -m : m;
  endfunction

  always_comb begin
    rsp_d.dir_x      = apply_sign(st_q[QW-1].q0, st_q[QW-1].neg[0], st_q[QW-1].degen);
    rsp_d.dir_y      = apply_sign(st_q[QW-1].q1, st_q[QW-1].neg[1], st_q[QW-1].degen);
    rsp_d.dir_z      = apply_sign(st_q[QW-1].q2, st_q[QW-1].neg[2], st_q[QW-1].degen);
    rsp_d.degenerate = st_q[QW-1].degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
      rsp_q  <= rsp_d;
    end
  end

  assign vld_o = vld_q[Stages-1];
  assign rsp_o = rsp_q;
endmodule

// ----- rtl/erd_checker.sv -----
// port level checks for eye_ray_direction_top, bound to the top level
// depends on erd_pkg
module erd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input erd_pkg::rsp_t out_rsp_o
);
  import erd_pkg::*;

  localparam logic signed [DirW-1:0] One = DirW'(16384);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.degenerate |->
      out_rsp_o.dir_x == '0 && out_rsp_o.dir_y == '0 && out_rsp_o.dir_z == '0)
    else $error("degenerate result with nonzero direction");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.dir_x <= One && out_rsp_o.dir_x >= -One &&
      out_rsp_o.dir_y <= One && out_rsp_o.dir_y >= -One &&
      out_rsp_o.dir_z <= One && out_rsp_o.dir_z >= -One)
    else $error("direction out of unit range");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request blocked with empty output");
endmodule

bind eye_ray_direction_top erd_checker u_erd_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_rsp_o
);
